FILE: src/bls_pkg.sv
package bls_pkg;

  localparam int COORD_W = 6;
  localparam int PITCH_W = 7;
  localparam int COLOR_W = 24;
  localparam int ADDR_W  = 12;
  localparam int ERR_W   = COORD_W + 3;

  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;
  localparam logic [CFG_AW-1:0] CFG_ADDR_PITCH = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_ADDR_COLOR = 3'd4;

  localparam logic [PITCH_W-1:0] PITCH_RESET = 7'd64;
  localparam logic [COLOR_W-1:0] COLOR_RESET = 24'hFFFFFF;

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
  } line_cmd_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [ADDR_W-1:0]  pixel_address;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_pixel;
  } pixel_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic last;
  } dp_sts_t;

endpackage

FILE: src/bls_ctrl.sv
module bls_ctrl
  import bls_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        // advance one pixel whenever the output register can take it
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          if (sts.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: src/bls_dp.sv
module bls_dp
  import bls_pkg::*;
#(
  parameter int TILE_SIZE = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  line_cmd_t          in_data,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  input  logic [PITCH_W-1:0] pitch,
  input  logic [COLOR_W-1:0] color,
  output logic               out_valid,
  input  logic               out_stall,
  output pixel_t             out_data
);

  localparam logic [COORD_W-1:0] MAX_C = COORD_W'(TILE_SIZE - 1);

  function automatic logic [COORD_W-1:0] clamp(input logic [COORD_W-1:0] v);
    clamp = (v > MAX_C) ? MAX_C : v;
  endfunction

  // captured endpoints
  logic [COORD_W-1:0] x0_r, y0_r, x1_r, y1_r;

  // stepping state
  logic [COORD_W-1:0] a_r, a1_r, b_r, da_r;
  logic [COORD_W:0]   inc_r;
  logic signed [ERR_W-1:0] err_r;
  logic steep_r, step_neg_r;

  logic   out_valid_r;
  pixel_t out_data_r;

  // setup arithmetic
  logic signed [COORD_W:0] dxs, dys;
  logic [COORD_W-1:0] adx, ady;
  logic steep;
  logic [COORD_W-1:0] sa0, sb0, sa1, sb1, oa0, ob0, oa1, ob1;

  always_comb begin
    dxs = $signed({1'b0, x0_r}) - $signed({1'b0, x1_r});
    dys = $signed({1'b0, y0_r}) - $signed({1'b0, y1_r});
    adx = dxs[COORD_W] ? COORD_W'(-dxs) : dxs[COORD_W-1:0];
    ady = dys[COORD_W] ? COORD_W'(-dys) : dys[COORD_W-1:0];
    steep = adx < ady;
    sa0 = steep ? y0_r : x0_r;
    sb0 = steep ? x0_r : y0_r;
    sa1 = steep ? y1_r : x1_r;
    sb1 = steep ? x1_r : y1_r;
    if (sa0 > sa1) begin
      oa0 = sa1; ob0 = sb1; oa1 = sa0; ob1 = sb0;
    end else begin
      oa0 = sa0; ob0 = sb0; oa1 = sa1; ob1 = sb1;
    end
  end

  // per-pixel step
  logic signed [ERR_W-1:0] err_add, corr;
  logic [COORD_W-1:0] px, py;
  logic [COORD_W+PITCH_W-1:0] prod;
  logic slot_free;

  always_comb begin
    px      = steep_r ? b_r : a_r;
    py      = steep_r ? a_r : b_r;
    prod    = py * pitch;
    corr    = $signed(ERR_W'({da_r, 1'b0}));
    err_add = err_r + $signed(ERR_W'(inc_r));
    slot_free = !out_valid_r || !out_stall;
  end

  assign sts.slot_free = slot_free;
  assign sts.last      = (a_r == a1_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x0_r <= clamp(in_data.start_x);
      y0_r <= clamp(in_data.start_y);
      x1_r <= clamp(in_data.end_x);
      y1_r <= clamp(in_data.end_y);
    end
    if (cmd.setup) begin
      a_r        <= oa0;
      a1_r       <= oa1;
      b_r        <= ob0;
      da_r       <= oa1 - oa0;
      inc_r      <= (ob1 > ob0) ? {ob1 - ob0, 1'b0} : {ob0 - ob1, 1'b0};
      err_r      <= '0;
      steep_r    <= steep;
      step_neg_r <= ob0 > ob1;
    end else if (cmd.emit) begin
      a_r <= a_r + 1'b1;
      if (err_add > $signed(ERR_W'(da_r))) begin
        b_r   <= step_neg_r ? b_r - 1'b1 : b_r + 1'b1;
        err_r <= err_add - corr;
      end else begin
        err_r <= err_add;
      end
    end
    if (cmd.emit) begin
      out_data_r.pixel_x       <= px;
      out_data_r.pixel_y       <= py;
      out_data_r.pixel_address <= ADDR_W'(prod) + ADDR_W'(px);
      out_data_r.pixel_color   <= color;
      out_data_r.last_pixel    <= (a_r == a1_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: src/bresenham_line_stepper_core.sv
// Bresenham line stepper: accepts one line command (two endpoints inside a
// TILE_SIZE square tile; coordinates above TILE_SIZE-1 saturate) and emits
// every pixel of the integer Bresenham line, one transfer per pixel, in
// order from the lower end of the major axis, with x/y in the original
// orientation, address x + y*line_pitch (mod 4096), draw_color and a flag on
// the last pixel. A line passes through an accept step (endpoint capture and
// clamp), a setup step (steep test, swap and ordering) and then the shared
// error-update step, one pixel per free output slot.
// A new command is taken only once the previous line's last pixel has been
// loaded into the output register. Registers: line_pitch at byte 0x0,
// draw_color at byte 0x4; write them only while the block is idle.
module bresenham_line_stepper_core
  import bls_pkg::*;
#(
  parameter int TILE_SIZE = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  // command channel
  input  logic              in_valid,
  output logic              in_stall,
  input  line_cmd_t         in_data,
  // pixel channel
  output logic              out_valid,
  input  logic              out_stall,
  output pixel_t            out_data,
  // configuration port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [PITCH_W-1:0] pitch_r;
  logic [COLOR_W-1:0] color_r;
  logic               cfg_wr;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Configuration registers: zero-wait writes, complete on the access phase.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r <= PITCH_RESET;
      color_r <= COLOR_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr)
        CFG_ADDR_PITCH: pitch_r <= cfg_pwdata[PITCH_W-1:0];
        CFG_ADDR_COLOR: color_r <= cfg_pwdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register; unmapped addresses read zero.
  always_comb begin
    unique case (cfg_paddr)
      CFG_ADDR_PITCH: cfg_prdata = CFG_DW'(pitch_r);
      CFG_ADDR_COLOR: cfg_prdata = CFG_DW'(color_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // Sequencer: idle -> setup -> run (one pixel per free output slot).
  bls_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Endpoint capture, swap/order setup, error stepping and output register.
  bls_dp #(
    .TILE_SIZE (TILE_SIZE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .pitch     (pitch_r),
    .color     (color_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import bls_pkg::*;

  localparam int TILE_SIZE = 64;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  line_cmd_t           in_data;
  logic                out_valid;
  logic                out_stall;
  pixel_t              out_data;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CFG_AW-1:0]   cfg_paddr;
  logic [CFG_DW-1:0]   cfg_pwdata;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  // Shadow copies of the two registers, updated as each write completes.
  logic [PITCH_W-1:0]  line_pitch_q;
  logic [COLOR_W-1:0]  draw_color_q;

  // Pixels still owed by the block, oldest first.
  pixel_t              expected_pixels[$];
  int                  mismatch_count;

  // Idle rates in percent, and a long output hold-off counted down per cycle.
  int                  sender_idle_pct;
  int                  receiver_stall_pct;
  int                  stall_hold_cycles;

  bresenham_line_stepper_core #(.TILE_SIZE(TILE_SIZE)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 8 ns clock period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int magnitude(int v);
    return (v < 0) ? -v : v;
  endfunction

  // Walk the line the way the block does and queue every pixel it must emit.
  function automatic void predict_line(line_cmd_t cmd);
    int  x0, y0, x1, y1, t;
    int  d_major, d_minor, err, minor_step, minor, major, n;
    bit  steep;
    pixel_t pix;
    x0 = cmd.start_x;
    y0 = cmd.start_y;
    x1 = cmd.end_x;
    y1 = cmd.end_y;
    // Swap axes for steep lines so the major axis is always the first one.
    steep = magnitude(x0 - x1) < magnitude(y0 - y1);
    if (steep) begin
      t = x0; x0 = y0; y0 = t;
      t = x1; x1 = y1; y1 = t;
    end
    // Order endpoints so the major coordinate rises.
    if (x0 > x1) begin
      t = x0; x0 = x1; x1 = t;
      t = y0; y0 = y1; y1 = t;
    end
    d_major    = x1 - x0;
    d_minor    = magnitude(y1 - y0);
    err        = 0;
    minor_step = (y0 > y1) ? -1 : 1;
    minor      = y0;
    n          = 0;
    for (major = x0; major <= x1 && n < TILE_SIZE; major++) begin
      pix.pixel_x       = COORD_W'(steep ? minor : major);
      pix.pixel_y       = COORD_W'(steep ? major : minor);
      pix.pixel_address = ADDR_W'(int'(pix.pixel_x) +
                                  int'(pix.pixel_y) * int'(line_pitch_q));
      pix.pixel_color   = draw_color_q;
      pix.last_pixel    = (major == x1);
      expected_pixels.push_back(pix);
      n++;
      err += 2 * d_minor;
      if (err > d_major) begin
        minor += minor_step;
        err   -= 2 * d_major;
      end
    end
  endfunction

  function automatic line_cmd_t line_of(int sx, int sy, int ex, int ey);
    line_cmd_t c;
    c.start_x = COORD_W'(sx);
    c.start_y = COORD_W'(sy);
    c.end_x   = COORD_W'(ex);
    c.end_y   = COORD_W'(ey);
    return c;
  endfunction

  // Mostly uniform endpoints; one line in four stays short by flipping low bits.
  function automatic line_cmd_t random_line();
    line_cmd_t c;
    c.start_x = COORD_W'($urandom_range(63));
    c.start_y = COORD_W'($urandom_range(63));
    c.end_x   = COORD_W'($urandom_range(63));
    c.end_y   = COORD_W'($urandom_range(63));
    if ($urandom_range(3) == 0) begin
      c.end_x = c.start_x ^ COORD_W'($urandom_range(7));
      c.end_y = c.start_y ^ COORD_W'($urandom_range(7));
    end
    return c;
  endfunction

  // Offer one command; hold the payload until the transfer, then predict it.
  // Enter and leave at a falling edge; leave valid high for a back-to-back send.
  task automatic send_line(line_cmd_t cmd);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (in_stall);
    predict_line(cmd);
    @(negedge clk);
  endtask

  // Drop valid and wait for every owed pixel, plus a margin.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // Write a register over the APB port, then read it back and check it.
  task automatic write_register(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] value);
    logic [CFG_DW-1:0] readback;
    logic [CFG_DW-1:0] want;
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(negedge clk) cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == CFG_ADDR_PITCH) begin
      line_pitch_q = value[PITCH_W-1:0];
      want         = CFG_DW'(line_pitch_q);
    end else begin
      draw_color_q = value[COLOR_W-1:0];
      want         = CFG_DW'(draw_color_q);
    end
    // Follow straight on with a read of the same address.
    @(negedge clk);
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk) cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    readback = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (readback !== want) begin
      $error("register 0x%0h readback: expected 0x%0h, got 0x%0h", addr, want, readback);
      mismatch_count++;
    end
  endtask

  // Corners, full-length axis lines both ways, diagonals, single points and
  // lines whose minor coordinate falls, all at the reset register values.
  task automatic test_directed_lines();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    send_line(line_of( 0,  0,  0,  0));
    send_line(line_of(63, 63, 63, 63));
    send_line(line_of( 0,  0, 63,  0));
    send_line(line_of(63, 63,  0, 63));
    send_line(line_of( 0,  0,  0, 63));
    send_line(line_of(63, 63, 63,  0));
    send_line(line_of( 0,  0, 63, 63));
    send_line(line_of(63,  0,  0, 63));
    send_line(line_of( 2, 10, 40,  3));
    send_line(line_of(10,  2,  3, 40));
    send_line(line_of( 5, 60,  9,  1));
    send_line(line_of( 0, 63, 63, 62));
    send_line(line_of(21, 42, 42, 21));
    wait_idle();
  endtask

  // Step through the register extremes: a pitch of one, zero pitch, a pitch
  // that wraps the address, the reset pitch, and black, white and odd colors.
  task automatic test_register_settings();
    logic [CFG_DW-1:0] pitches[4];
    logic [CFG_DW-1:0] colors[4];
    pitches = '{32'd1, 32'd0, 32'd127, 32'd64};
    colors  = '{32'h000000, CFG_DW'($urandom_range(24'hFFFFFF)), 32'hFFFFFF, 32'h5A_A5_3C};
    for (int i = 0; i < 4; i++) begin
      write_register(CFG_ADDR_PITCH, pitches[i]);
      write_register(CFG_ADDR_COLOR, colors[i]);
      send_line(line_of(63, 63, 0, 0));
      send_line(line_of(0, 63, 63, 40));
      send_line(random_line());
      wait_idle();
    end
  endtask

  // A run of random lines under one idling mode and a fresh register setting.
  task automatic test_random_lines(int idle_pct, int stall_pct, int count);
    write_register(CFG_ADDR_PITCH, CFG_DW'($urandom_range(1, 64)));
    write_register(CFG_ADDR_COLOR, CFG_DW'($urandom_range(24'hFFFFFF)));
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (count) send_line(random_line());
    wait_idle();
  endtask

  // Hold the output off for a long stretch while commands keep coming, so the
  // block backs up and stalls its input; then let it drain.
  task automatic test_backpressure();
    write_register(CFG_ADDR_PITCH, CFG_DW'($urandom_range(127)));
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    stall_hold_cycles  = 300;
    repeat (20) send_line(random_line());
    wait_idle();
  endtask

  // Receiver side: a pending hold-off wins, else stall at the current rate.
  always @(negedge clk) begin
    if (stall_hold_cycles > 0) begin
      out_stall         <= 1'b1;
      stall_hold_cycles <= stall_hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // Check every pixel transfer against the oldest owed pixel, field by field.
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $error("pixel transfer with none owed: x=%0d y=%0d", out_data.pixel_x, out_data.pixel_y);
        mismatch_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_data.pixel_x !== want.pixel_x) begin
          $error("pixel_x: expected %0d, got %0d", want.pixel_x, out_data.pixel_x);
          mismatch_count++;
        end
        if (out_data.pixel_y !== want.pixel_y) begin
          $error("pixel_y: expected %0d, got %0d", want.pixel_y, out_data.pixel_y);
          mismatch_count++;
        end
        if (out_data.pixel_address !== want.pixel_address) begin
          $error("pixel_address: expected %0d, got %0d",
                 want.pixel_address, out_data.pixel_address);
          mismatch_count++;
        end
        if (out_data.pixel_color !== want.pixel_color) begin
          $error("pixel_color: expected 0x%06h, got 0x%06h",
                 want.pixel_color, out_data.pixel_color);
          mismatch_count++;
        end
        if (out_data.last_pixel !== want.last_pixel) begin
          $error("last_pixel: expected %0b, got %0b", want.last_pixel, out_data.last_pixel);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    // Drive every input to a known value before the first edge.
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_data            = '0;
    out_stall          = 1'b0;
    cfg_psel           = 1'b0;
    cfg_penable        = 1'b0;
    cfg_pwrite         = 1'b0;
    cfg_paddr          = '0;
    cfg_pwdata         = '0;
    line_pitch_q       = PITCH_RESET;
    draw_color_q       = COLOR_RESET;
    mismatch_count     = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    stall_hold_cycles  = 0;

    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    @(negedge clk);

    test_directed_lines();
    test_register_settings();
    test_random_lines(0, 0, 50);
    test_random_lines(77, 0, 50);
    test_random_lines(0, 77, 50);
    test_random_lines(36, 36, 50);
    test_backpressure();

    // Let any trailing activity settle before the verdict.
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
